/* sv/ddp_pkt_pkg.sv */
`default_nettype none

package ddp_pkt_pkg;

    // header layout
    localparam int unsigned HDR_LEN = 10;
    localparam int unsigned IDX_W   = 4;
    localparam logic [IDX_W-1:0] PAYLOAD_IDX = IDX_W'(HDR_LEN);

    localparam logic [3:0] SEQ_TOP   = 4'd15;
    localparam logic [3:0] SEQ_FIRST = 4'd1;
    localparam logic [7:0] FLAG_VER1 = 8'h40;
    localparam logic [7:0] FLAG_PUSH = 8'h01;
    localparam logic [7:0] DATA_TYPE = 8'h01;
    localparam logic [7:0] DEST_ID   = 8'h01;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_CHANNEL = 2'd0,
        REG_CHANNEL_COUNT = 2'd1,
        REG_PACKET_SIZE   = 2'd2,
        REG_KEEP_CHANNELS = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [24:0] start_channel;
        logic [23:0] channel_count;
        logic [10:0] packet_size;
        logic        keep_channels;
    } cfg_t;

    // one accepted byte together with the header it opens, if any
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_header;
        logic        push;
        logic [3:0]  seq;
        logic [31:0] offset;
        logic [10:0] len;
        logic        packet_last;
        logic        frame_last;
    } desc_t;

    // serializer status toward the top level
    typedef struct packed {
        logic slot_free;
        logic slot_done;
    } ser_stat_t;

endpackage

`default_nettype wire

/* sv/ddp_pkt_if.sv */
`default_nettype none

interface ddp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface ddp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_header;
    logic       packet_last;
    logic       frame_last;

    modport source (output valid, output out_byte, output is_header,
                    output packet_last, output frame_last, input ready);
    modport sink (input valid, input out_byte, input is_header,
                  input packet_last, input frame_last, output ready);
endinterface

interface ddp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [24:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/ddp_pkt_cfg.sv */
`default_nettype none

module ddp_pkt_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    ddp_cfg_if.sink            cfg,
    output ddp_pkt_pkg::cfg_t  regs
);
    import ddp_pkt_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // register write decode
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_START_CHANNEL: regs_next.start_channel = cfg.data;
                REG_CHANNEL_COUNT: regs_next.channel_count = cfg.data[23:0];
                REG_PACKET_SIZE:   regs_next.packet_size   = cfg.data[10:0];
                REG_KEEP_CHANNELS: regs_next.keep_channels = cfg.data[0];
                default:           regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.start_channel <= 25'd1;
            regs_reg.channel_count <= 24'd0;
            regs_reg.packet_size   <= 11'd1440;
            regs_reg.keep_channels <= 1'b0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

/* sv/ddp_pkt_ctrl.sv */
`default_nettype none

module ddp_pkt_ctrl #(
    parameter int unsigned MAX_PAYLOAD = 1440
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ddp_pkt_pkg::cfg_t regs,
    input  wire logic           accept,
    input  wire logic [7:0]     data_byte,
    output ddp_pkt_pkg::desc_t  desc,
    output logic                desc_push
);
    import ddp_pkt_pkg::*;

    localparam logic [10:0] MAX_LEN = MAX_PAYLOAD[10:0];

    logic [3:0]  seq_reg, seq_next;
    logic [23:0] frame_left_reg, frame_left_next;
    logic [10:0] pkt_left_reg, pkt_left_next;
    logic [31:0] offset_reg, offset_next;

    logic        frame_start;
    logic        drop;
    logic        pkt_start;
    logic [24:0] start_eff;
    logic [23:0] frame_left_eff;
    logic [31:0] offset_eff;
    logic [10:0] size_eff;
    logic [10:0] len;
    logic [10:0] pkt_left_eff;

    // frame and packet bookkeeping for the byte at the input
    always_comb
    begin
        frame_start = (frame_left_reg == 24'd0);
        drop        = frame_start && (regs.channel_count == 24'd0);
        pkt_start   = (pkt_left_reg == 11'd0);

        start_eff      = (regs.start_channel == 25'd0) ? 25'd1 : regs.start_channel;
        frame_left_eff = frame_start ? regs.channel_count : frame_left_reg;
        if (frame_start)
            offset_eff = regs.keep_channels ? {7'd0, start_eff - 25'd1} : 32'd0;
        else
            offset_eff = offset_reg;

        if (regs.packet_size == 11'd0)
            size_eff = 11'd1;
        else if (regs.packet_size > MAX_LEN)
            size_eff = MAX_LEN;
        else
            size_eff = regs.packet_size;

        len = (frame_left_eff < {13'd0, size_eff}) ? frame_left_eff[10:0] : size_eff;
        pkt_left_eff = pkt_start ? len : pkt_left_reg;
    end

    // request toward the serializer
    always_comb
    begin
        desc.data_byte   = data_byte;
        desc.has_header  = pkt_start;
        desc.push        = ({13'd0, len} == frame_left_eff);
        desc.seq         = seq_reg;
        desc.offset      = offset_eff;
        desc.len         = len;
        desc.packet_last = (pkt_left_eff == 11'd1);
        desc.frame_last  = (frame_left_eff == 24'd1);
        desc_push        = accept && !drop;
    end

    // state update on every byte that is kept
    always_comb
    begin
        seq_next        = seq_reg;
        frame_left_next = frame_left_reg;
        pkt_left_next   = pkt_left_reg;
        offset_next     = offset_reg;
        if (desc_push)
        begin
            frame_left_next = frame_left_eff - 24'd1;
            pkt_left_next   = pkt_left_eff - 11'd1;
            offset_next     = offset_eff + 32'd1;
            if (pkt_start)
                seq_next = (seq_reg >= SEQ_TOP) ? SEQ_FIRST : seq_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg        <= SEQ_FIRST;
            frame_left_reg <= 24'd0;
            pkt_left_reg   <= 11'd0;
            offset_reg     <= 32'd0;
        end
        else
        begin
            seq_reg        <= seq_next;
            frame_left_reg <= frame_left_next;
            pkt_left_reg   <= pkt_left_next;
            offset_reg     <= offset_next;
        end
    end

endmodule

`default_nettype wire

/* sv/ddp_pkt_ser.sv */
`default_nettype none

module ddp_pkt_ser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ddp_pkt_pkg::desc_t desc,
    input  wire logic              desc_push,
    output ddp_pkt_pkg::ser_stat_t stat,
    ddp_out_if.source              pkt
);
    import ddp_pkt_pkg::*;

    desc_t            desc_reg;
    logic             slot_valid_reg, slot_valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_hdr_reg;
    logic       out_plast_reg;
    logic       out_flast_reg;

    logic       load_out;
    logic       emit;
    logic [7:0] cur_byte;
    logic       cur_hdr;

    assign load_out = !out_valid_reg || pkt.ready;
    assign emit     = slot_valid_reg && load_out;

    assign stat.slot_done = emit && (idx_reg == PAYLOAD_IDX);
    assign stat.slot_free = !slot_valid_reg || stat.slot_done;

    // byte select for the current position in the packet
    always_comb
    begin
        cur_hdr = 1'b1;
        case (idx_reg)
            4'd0:    cur_byte = FLAG_VER1 | (desc_reg.push ? FLAG_PUSH : 8'h00);
            4'd1:    cur_byte = {4'd0, desc_reg.seq};
            4'd2:    cur_byte = DATA_TYPE;
            4'd3:    cur_byte = DEST_ID;
            4'd4:    cur_byte = desc_reg.offset[31:24];
            4'd5:    cur_byte = desc_reg.offset[23:16];
            4'd6:    cur_byte = desc_reg.offset[15:8];
            4'd7:    cur_byte = desc_reg.offset[7:0];
            4'd8:    cur_byte = {5'd0, desc_reg.len[10:8]};
            4'd9:    cur_byte = desc_reg.len[7:0];
            default:
            begin
                cur_byte = desc_reg.data_byte;
                cur_hdr  = 1'b0;
            end
        endcase
    end

    // request slot and position counter
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        idx_next        = idx_reg;
        if (desc_push)
        begin
            slot_valid_next = 1'b1;
            idx_next        = desc.has_header ? '0 : PAYLOAD_IDX;
        end
        else if (stat.slot_done)
        begin
            slot_valid_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            idx_reg        <= idx_next;
            if (load_out)
                out_valid_reg <= emit;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (desc_push)
            desc_reg <= desc;
        if (emit)
        begin
            out_byte_reg  <= cur_byte;
            out_hdr_reg   <= cur_hdr;
            out_plast_reg <= !cur_hdr && desc_reg.packet_last;
            out_flast_reg <= !cur_hdr && desc_reg.frame_last;
        end
    end

    assign pkt.valid       = out_valid_reg;
    assign pkt.out_byte    = out_byte_reg;
    assign pkt.is_header   = out_hdr_reg;
    assign pkt.packet_last = out_plast_reg;
    assign pkt.frame_last  = out_flast_reg;

endmodule

`default_nettype wire

/* sv/ddp_packetizer_core.sv */
// ddp packetizer: turns a stream of light channel bytes into ddp packets
// frame_data carries one channel byte per request, in channel order
// packet carries the packet stream one byte per request: a ten-byte header
// (is_header set) before the first payload byte of each packet
// cfg writes start_channel, channel_count, packet_size, keep_channels by
// index 0..3; write only while no request is in flight
// a byte that opens a packet yields 11 output bytes, any other byte yields 1;
// with channel_count zero bytes are taken and dropped
// the first output byte passes the request slot register and then the output register
// throughput: one output byte per cycle while the receiver is ready, set by
// the output register; payload bytes enter at one per cycle while the output
// does not stall, a packet-opening byte holds the input while its header drains
// reset clears the counters, sets the sequence number to 1 and loads the
// register defaults; no clearing pass
// when the receiver stalls the output register holds and one more request
// is buffered before frame_data.ready drops
`default_nettype none

module ddp_packetizer_core #(
    parameter int unsigned MAX_PAYLOAD = 1440
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ddp_in_if.sink     frame_data,
    ddp_out_if.source  packet,
    ddp_cfg_if.sink    cfg
);
    import ddp_pkt_pkg::*;

    cfg_t      regs;
    desc_t     desc;
    logic      desc_push;
    logic      accept;
    ser_stat_t ser_stat;

    assign frame_data.ready = ser_stat.slot_free;
    assign accept           = frame_data.valid && frame_data.ready;

    ddp_pkt_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    ddp_pkt_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .accept    (accept),
        .data_byte (frame_data.data_byte),
        .desc      (desc),
        .desc_push (desc_push)
    );

    ddp_pkt_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .desc      (desc),
        .desc_push (desc_push),
        .stat      (ser_stat),
        .pkt       (packet)
    );

    // frame end always closes a packet
    a_frame_closes_packet: assert property (@(posedge clk) disable iff (!rst_n)
        packet.valid && packet.frame_last |-> packet.packet_last)
        else $error("frame_last without packet_last");

    // header bytes never carry end markers
    a_header_no_last: assert property (@(posedge clk) disable iff (!rst_n)
        packet.valid && packet.is_header |-> !packet.packet_last && !packet.frame_last)
        else $error("end marker on a header byte");

    // a new request only lands in a free slot
    a_slot_free_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        desc_push |-> ser_stat.slot_free)
        else $error("request overwrote a busy slot");

endmodule

`default_nettype wire

/* verif/ddp_packetizer_core_tb.sv */
`timescale 1ns / 1ps

module ddp_packetizer_core_tb;

    import ddp_pkt_pkg::*;

    localparam int unsigned MAX_PAYLOAD   = 1440;
    localparam int unsigned RANDOM_ITEMS  = 300;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned STALL_LIMIT   = 2000;

    // one byte of the outgoing packet stream
    typedef struct {
        logic [7:0] value;
        logic       hdr;
        logic       plast;
        logic       flast;
    } pkt_byte_t;

    // packet stream predictor and expected byte store
    class packet_scoreboard;
        logic [24:0] start_channel;
        logic [23:0] channel_count;
        logic [10:0] packet_size;
        logic        keep_channels;
        logic [3:0]  seq_num;
        logic [23:0] frame_left;
        logic [10:0] packet_left;
        logic [31:0] offset;
        pkt_byte_t   expected_bytes[$];
        int          failures;

        function new();
            start_channel = 25'd1;
            channel_count = 24'd0;
            packet_size   = 11'd1440;
            keep_channels = 1'b0;
            seq_num       = SEQ_FIRST;
            frame_left    = '0;
            packet_left   = '0;
            offset        = '0;
            failures      = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [24:0] value);
            case (idx)
                REG_START_CHANNEL: start_channel = value;
                REG_CHANNEL_COUNT: channel_count = value[23:0];
                REG_PACKET_SIZE:   packet_size   = value[10:0];
                REG_KEEP_CHANNELS: keep_channels = value[0];
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] value, logic hdr, logic plast, logic flast);
            pkt_byte_t b;
            b.value = value;
            b.hdr   = hdr;
            b.plast = plast;
            b.flast = flast;
            expected_bytes.push_back(b);
        endfunction

        // note one accepted channel byte, returns the number of bytes it yields
        function int note_frame_byte(logic [7:0] value);
            logic [24:0] first_ch;
            logic [10:0] size;
            logic [10:0] len;
            int          n;
            n = 0;
            // frame start: load counters and the channel offset
            if (frame_left == 0) begin
                if (channel_count == 0)
                    return 0;
                frame_left = channel_count;
                first_ch   = (start_channel == 0) ? 25'd1 : start_channel;
                offset     = keep_channels ? (32'(first_ch) - 32'd1) : 32'd0;
            end
            // packet start: ten header bytes
            if (packet_left == 0) begin
                size = packet_size;
                if (size == 0)
                    size = 11'd1;
                if (size > MAX_PAYLOAD)
                    size = 11'(MAX_PAYLOAD);
                len = (frame_left < 24'(size)) ? frame_left[10:0] : size;
                packet_left = len;
                push_byte(FLAG_VER1 | ((24'(len) == frame_left) ? FLAG_PUSH : 8'h00),
                          1'b1, 1'b0, 1'b0);
                push_byte({4'h0, seq_num}, 1'b1, 1'b0, 1'b0);
                push_byte(DATA_TYPE, 1'b1, 1'b0, 1'b0);
                push_byte(DEST_ID, 1'b1, 1'b0, 1'b0);
                push_byte(offset[31:24], 1'b1, 1'b0, 1'b0);
                push_byte(offset[23:16], 1'b1, 1'b0, 1'b0);
                push_byte(offset[15:8], 1'b1, 1'b0, 1'b0);
                push_byte(offset[7:0], 1'b1, 1'b0, 1'b0);
                push_byte({5'd0, len[10:8]}, 1'b1, 1'b0, 1'b0);
                push_byte(len[7:0], 1'b1, 1'b0, 1'b0);
                n = n + 10;
                seq_num = (seq_num >= SEQ_TOP) ? SEQ_FIRST : seq_num + 4'd1;
            end
            // payload byte
            packet_left = packet_left - 11'd1;
            frame_left  = frame_left - 24'd1;
            offset      = offset + 32'd1;
            push_byte(value, 1'b0, packet_left == 0, frame_left == 0);
            return n + 1;
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                failures++;
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, want, got);
            end
        endfunction

        function void check_packet_byte(logic [7:0] value, logic hdr, logic plast,
                                        logic flast);
            pkt_byte_t want;
            if (expected_bytes.size() == 0) begin
                failures++;
                $display("%0t: unexpected packet byte, expected none, actual %h",
                         $time, value);
                return;
            end
            want = expected_bytes.pop_front();
            compare_field("out_byte", want.value, value);
            compare_field("is_header", {7'd0, want.hdr}, {7'd0, hdr});
            compare_field("packet_last", {7'd0, want.plast}, {7'd0, plast});
            compare_field("frame_last", {7'd0, want.flast}, {7'd0, flast});
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ddp_in_if  frame_if ();
    ddp_out_if packet_if ();
    ddp_cfg_if cfg_if ();

    ddp_packetizer_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_data (frame_if),
        .packet     (packet_if),
        .cfg        (cfg_if)
    );

    packet_scoreboard predictor = new();
    int  burst_left = 0;
    int  producing_items = 0;
    bit  hold_off_pending = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // offer one channel byte and wait for its request to be taken
    task automatic send_frame_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                frame_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        frame_if.valid     <= 1'b1;
        frame_if.data_byte <= value;
        @(posedge clk);
        while (frame_if.ready !== 1'b1)
            @(posedge clk);
        if (predictor.note_frame_byte(value) != 0)
            producing_items++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_random_bytes(input int count);
        for (int i = 0; i < count; i++)
            send_frame_byte(8'($urandom));
        frame_if.valid <= 1'b0;
    endtask

    // write all four registers back to back
    task automatic program_regs(input logic [24:0] first_ch, input logic [23:0] count,
                                input logic [10:0] size, input logic keep);
        cfg_reg_t    regs[4] = '{REG_START_CHANNEL, REG_CHANNEL_COUNT,
                                 REG_PACKET_SIZE, REG_KEEP_CHANNELS};
        logic [24:0] vals[4];
        vals[0] = first_ch;
        vals[1] = 25'(count);
        vals[2] = 25'(size);
        vals[3] = 25'(keep);
        for (int i = 0; i < 4; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= regs[i];
            cfg_if.data  <= vals[i];
            @(posedge clk);
            while (cfg_if.ready !== 1'b1)
                @(posedge clk);
            predictor.write_reg(regs[i], vals[i]);
            @(negedge clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // wait until every expected byte is out and the block has settled
    task automatic wait_drained();
        while (predictor.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // output side ready pattern, with one long hold-off on request
    initial
    begin
        int mode;
        int tick;
        int held;
        mode = 0;
        tick = 0;
        packet_if.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_pending) begin
                packet_if.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(negedge clk);
                    held++;
                end
                hold_off_pending = 1'b0;
            end else begin
                if (tick % 50 == 0)
                    mode = $urandom_range(0, 3);
                tick++;
                case (mode)
                    0: packet_if.ready <= 1'b1;
                    1: packet_if.ready <= ($urandom_range(0, 3) != 0);
                    2: packet_if.ready <= ($urandom_range(0, 3) == 0);
                    default: packet_if.ready <= (tick % 4 != 3);
                endcase
            end
        end
    end

    // check every packet byte taken
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && packet_if.valid === 1'b1 && packet_if.ready === 1'b1)
            predictor.check_packet_byte(packet_if.out_byte, packet_if.is_header,
                                        packet_if.packet_last, packet_if.frame_last);
    end

    // watchdog on cycles without any request taken
    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((frame_if.valid === 1'b1 && frame_if.ready === 1'b1) ||
                (packet_if.valid === 1'b1 && packet_if.ready === 1'b1) ||
                (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("tb: failure");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [24:0] first_ch;
        logic [23:0] count;
        logic [10:0] size;
        bit          first_phase;
        int          n;

        rst_n              <= 1'b0;
        frame_if.valid     <= 1'b0;
        frame_if.data_byte <= 8'h00;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= REG_START_CHANNEL;
        cfg_if.data        <= '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero channel count after reset: bytes are dropped
        send_frame_byte(8'h12);
        send_frame_byte(8'hED);
        send_frame_byte(8'h00);
        frame_if.valid <= 1'b0;
        wait_drained();

        // small packets, kept offset, byte extremes
        program_regs(25'd1, 24'd5, 11'd2, 1'b1);
        send_frame_byte(8'h00);
        send_frame_byte(8'hFF);
        send_frame_byte(8'h55);
        send_frame_byte(8'hAA);
        send_frame_byte(8'h01);
        frame_if.valid <= 1'b0;
        wait_drained();

        // start channel zero and packet size zero
        program_regs(25'd0, 24'd3, 11'd0, 1'b1);
        send_random_bytes(3);
        wait_drained();

        // largest start channel, packet size above the limit
        program_regs(25'h1FFFFFF, 24'd4, 11'h7FF, 1'b1);
        send_random_bytes(4);
        wait_drained();

        // register writes in the middle of a frame
        program_regs(25'd1, 24'd4, 11'd3, 1'b0);
        send_random_bytes(2);
        wait_drained();
        program_regs(25'd7, 24'd2, 11'd1, 1'b1);
        send_random_bytes(4);
        wait_drained();

        // random settings with random channel bytes
        producing_items = 0;
        first_phase = 1'b1;
        while (producing_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: first_ch = 25'd0;
                1: first_ch = 25'd1;
                2: first_ch = 25'd16777216;
                3: first_ch = 25'h1FFFFFF;
                default: first_ch = 25'($urandom);
            endcase
            if ($urandom_range(0, 11) == 0)
                count = 24'd0;
            else if ($urandom_range(0, 7) == 0)
                count = 24'($urandom_range(41, 200));
            else
                count = 24'($urandom_range(1, 40));
            case ($urandom_range(0, 9))
                0: size = 11'd0;
                1: size = 11'd1;
                2: size = 11'd1440;
                3: size = 11'h7FF;
                4: size = 11'($urandom_range(1441, 2047));
                default: size = 11'($urandom_range(1, 12));
            endcase
            program_regs(first_ch, count, size, 1'($urandom));
            n = $urandom_range(1, 60);
            if (first_phase) begin
                // long output stall while channel bytes keep coming
                hold_off_pending = 1'b1;
                n = 48;
                first_phase = 1'b0;
            end
            send_random_bytes(n);
            wait_drained();
        end

        // finish the open frame, then the largest channel count
        if (predictor.frame_left != 0) begin
            send_random_bytes(int'(predictor.frame_left));
            wait_drained();
        end
        program_regs(25'd16777216, 24'hFFFFFF, 11'd1440, 1'b1);
        send_random_bytes(25);
        wait_drained();

        if (predictor.failures == 0 && predictor.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
